@@ hw/rtl/distance_sensor_wall_relocalize_top_assert.svh @@
// Assertion macros for the relocalizer checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef DISTANCE_SENSOR_WALL_RELOCALIZE_TOP_ASSERT_SVH
`define DISTANCE_SENSOR_WALL_RELOCALIZE_TOP_ASSERT_SVH

// same-cycle implication
`define DSWR_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DSWR_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/dswr_pkg.sv @@
// Types, constants and sine table for the distance sensor relocalizer.
// No dependencies.
package dswr_pkg;

    localparam int ARENA_HALF = 14400;
    localparam int NO_DETECT  = 9999;
    localparam int MIN_PERP   = 11469;
    localparam int FULL_TURN  = 23040;
    localparam int QTR_TURN   = 5760;
    localparam int N_REGS     = 8;

    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic [14:0]        heading;
        logic [3:0]         sensor_present;
        logic [13:0]        front_distance;
        logic [13:0]        back_distance;
        logic [13:0]        left_distance;
        logic [13:0]        right_distance;
    } t_in;

    typedef struct packed {
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic               x_updated;
        logic               y_updated;
        logic [1:0]         x_sensor;
        logic [1:0]         y_sensor;
    } t_out;

    // one classified request in the queue
    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic signed [15:0] s;
        logic signed [15:0] c;
        logic [3:0]         use_mask;
        logic [3:0][13:0]   reading;
    } t_cls;

    typedef struct packed {
        logic signed [12:0] x;
        logic signed [12:0] y;
    } t_mount;

    localparam logic [14:0] SIN_DEG [0:90] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
        15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
        15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
        15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
        15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
        15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    // first quadrant, a in 0..5760, interpolated over 1/64 degree
    function automatic logic [14:0] sin_quarter(input logic [12:0] a);
        logic [6:0]  k;
        logic [5:0]  f;
        logic [8:0]  diff;
        logic [15:0] prod;
        k = a[12:6];
        f = a[5:0];
        if (k >= 7'd90) begin
            return SIN_DEG[90];
        end
        diff = 9'(SIN_DEG[7'(k + 7'd1)] - SIN_DEG[k]);
        prod = 16'(diff) * 16'(f) + 16'd32;
        return SIN_DEG[k] + 15'(prod[15:6]);
    endfunction

    // h already below one full turn
    function automatic logic signed [15:0] sin_fix(input logic [14:0] h);
        logic [14:0] q;
        priority if (h < 15'(QTR_TURN)) begin
            return $signed({1'b0, sin_quarter(h[12:0])});
        end else if (h < 15'(2 * QTR_TURN)) begin
            q = 15'(2 * QTR_TURN) - h;
            return $signed({1'b0, sin_quarter(q[12:0])});
        end else if (h < 15'(3 * QTR_TURN)) begin
            q = h - 15'(2 * QTR_TURN);
            return -$signed({1'b0, sin_quarter(q[12:0])});
        end else begin
            q = 15'(FULL_TURN) - h;
            return -$signed({1'b0, sin_quarter(q[12:0])});
        end
    endfunction

endpackage

@@ hw/rtl/distance_sensor_wall_relocalize_top.sv @@
// Distance sensor wall relocalizer: top level.
// Request channel: i_valid / o_stall with i_data (pose, heading, present
//   mask, four readings). A request transfers when i_valid is high and
//   o_stall is low. o_stall rises only when the two-entry queue is full.
// Result channel: o_valid / i_stall with o_data (new pose, update flags,
//   winning sensors). One result per request, in request order.
// Configuration: i_cfg_we writes i_cfg_wdata into mount register i_cfg_idx
//   (front x, front y, back x, back y, left x, left y, right x, right y);
//   indexes 8 and above are ignored. Write only while idle.
// The back end pushes one sensor per cycle, unless a held result stalls it,
//   through its rotate / wall / select pipeline, overlapping requests.
// A transferred request is queued; its four sensors issue from the queue head
//   and pass stages A, B and C into the result register.
// Reset (synchronous, i_rst_n low): queue and pipeline empty, o_valid low,
//   mount registers cleared to zero.
// While i_stall holds a result, the back end freezes and the queue fills;
//   o_data stays unchanged until it transfers.
// Depends on dswr_pkg, dswr_front, dswr_fifo, dswr_back.
module distance_sensor_wall_relocalize_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  dswr_pkg::t_in        i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output dswr_pkg::t_out       o_data,
    input  logic                 i_cfg_we,
    input  logic [3:0]           i_cfg_idx,
    input  logic signed [12:0]   i_cfg_wdata
);
    dswr_pkg::t_mount [3:0] r_mount;
    dswr_pkg::t_cls cls, q_head;
    logic full, empty, pop, push;

    assign o_stall = full;
    assign push    = i_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mount <= '0;
        end else if (i_cfg_we && (i_cfg_idx < 4'(dswr_pkg::N_REGS))) begin
            if (i_cfg_idx[0]) begin
                r_mount[i_cfg_idx[2:1]].y <= i_cfg_wdata;
            end else begin
                r_mount[i_cfg_idx[2:1]].x <= i_cfg_wdata;
            end
        end
    end

    dswr_front u_front (
        .i_item (i_data),
        .o_cls  (cls)
    );

    dswr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (cls),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_rdata (q_head)
    );

    dswr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cls   (q_head),
        .o_pop   (pop),
        .i_mount (r_mount),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );
endmodule

@@ hw/rtl/dswr_front.sv @@
// Front end: wraps the heading, looks up sine and cosine, marks usable readings.
// Depends on dswr_pkg.
module dswr_front (
    input  dswr_pkg::t_in  i_item,
    output dswr_pkg::t_cls o_cls
);
    logic [14:0] h0;
    logic [15:0] h1w;
    logic [14:0] h1;
    logic [3:0][13:0] reading;

    always_comb begin
        h0  = (i_item.heading >= 15'(dswr_pkg::FULL_TURN)) ?
              i_item.heading - 15'(dswr_pkg::FULL_TURN) : i_item.heading;
        h1w = {1'b0, h0} + 16'(dswr_pkg::QTR_TURN);
        h1  = (h1w >= 16'(dswr_pkg::FULL_TURN)) ?
              15'(h1w - 16'(dswr_pkg::FULL_TURN)) : h1w[14:0];
        reading[0] = i_item.front_distance;
        reading[1] = i_item.back_distance;
        reading[2] = i_item.left_distance;
        reading[3] = i_item.right_distance;
        o_cls.pose_x  = i_item.pose_x;
        o_cls.pose_y  = i_item.pose_y;
        o_cls.s       = dswr_pkg::sin_fix(h0);
        o_cls.c       = dswr_pkg::sin_fix(h1);
        o_cls.reading = reading;
        for (int i = 0; i < 4; i++) begin
            o_cls.use_mask[i] = i_item.sensor_present[i] && (reading[i] != 14'd0) &&
                                (reading[i] < 14'(dswr_pkg::NO_DETECT));
        end
    end
endmodule

@@ hw/rtl/dswr_fifo.sv @@
// Two-entry queue between the front end and the ray back end.
// Depends on dswr_pkg.
module dswr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dswr_pkg::t_cls i_wdata,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output dswr_pkg::t_cls o_rdata
);
    dswr_pkg::t_cls r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end
endmodule

@@ hw/rtl/dswr_back.sv @@
// Back end: one sensor per cycle through rotate, wall pick, back-out and select.
// Depends on dswr_pkg; freezes whole when the result register is stalled.
module dswr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  dswr_pkg::t_cls        i_cls,
    output logic                  o_pop,
    input  dswr_pkg::t_mount [3:0] i_mount,
    output logic                  o_valid,
    input  logic                  i_stall,
    output dswr_pkg::t_out        o_data
);
    localparam logic signed [18:0] FH19 = 19'(dswr_pkg::ARENA_HALF);
    localparam logic signed [23:0] FH24 = 24'(dswr_pkg::ARENA_HALF);

    logic adv, issue;
    logic [1:0] r_idx;

    // stage A: rotation products
    logic r_a_v, r_a_use;
    logic [1:0] r_a_idx;
    logic signed [15:0] r_a_px, r_a_py, r_a_dx, r_a_dy;
    logic [13:0] r_a_r;
    logic signed [28:0] r_a_cmx, r_a_smy, r_a_smx, r_a_cmy;
    // stage B: offsets and wall distances
    logic r_b_v, r_b_use, r_b_hx, r_b_hy;
    logic [1:0] r_b_idx;
    logic signed [15:0] r_b_px, r_b_py, r_b_dx, r_b_dy, r_b_ox, r_b_oy;
    logic [13:0] r_b_r;
    logic [16:0] r_b_nx, r_b_ny;
    // stage C: cross products and reading products
    logic r_c_v, r_c_use, r_c_hx, r_c_hy;
    logic [1:0] r_c_idx;
    logic signed [15:0] r_c_px, r_c_py, r_c_dx, r_c_dy, r_c_ox, r_c_oy;
    logic [31:0] r_c_qx, r_c_qy;
    logic signed [30:0] r_c_rdx, r_c_rdy;
    // running best per axis
    logic r_bx_ok, r_by_ok;
    logic [14:0] r_bx_q, r_by_q;
    logic [1:0] r_bx_i, r_by_i;
    logic signed [15:0] r_bx_v, r_by_v;
    logic r_out_v;
    dswr_pkg::t_out r_out;

    logic signed [15:0] dx, dy, ox, oy;
    dswr_pkg::t_mount mnt;
    logic signed [29:0] sum_x, sum_y;
    logic signed [17:0] sx, sy;
    logic signed [18:0] nsx, nsy;
    logic [14:0] adx, ady;
    logic ax_y, hit, ok;
    logic signed [15:0] d, o;
    logic [14:0] perp;
    logic signed [30:0] rd;
    logic signed [31:0] rt;
    logic signed [20:0] rr;
    logic signed [23:0] coord;
    logic bx_ok, by_ok;
    logic [14:0] bx_q, by_q;
    logic [1:0] bx_i, by_i;
    logic signed [15:0] bx_v, by_v;

    assign adv   = !r_out_v || !i_stall;
    assign issue = adv && !i_empty;
    assign o_pop = issue && (r_idx == 2'd3);
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // issue: pick direction of the current sensor
    always_comb begin
        mnt = i_mount[r_idx];
        unique case (r_idx)
            2'd0: begin dx = i_cls.s;  dy = i_cls.c;  end
            2'd1: begin dx = -i_cls.s; dy = -i_cls.c; end
            2'd2: begin dx = -i_cls.c; dy = i_cls.s;  end
            default: begin dx = i_cls.c; dy = -i_cls.s; end
        endcase
    end

    // stage B logic
    always_comb begin
        sum_x = -30'(r_a_cmx) + 30'(r_a_smy) + 30'sd8192;
        sum_y = 30'(r_a_smx) + 30'(r_a_cmy) + 30'sd8192;
        ox  = 16'(sum_x >>> 14);
        oy  = 16'(sum_y >>> 14);
        sx  = 18'(r_a_px) + 18'(ox);
        sy  = 18'(r_a_py) + 18'(oy);
        nsx = r_a_dx[15] ? FH19 + 19'(sx) : FH19 - 19'(sx);
        nsy = r_a_dy[15] ? FH19 + 19'(sy) : FH19 - 19'(sy);
    end

    // stage D logic: wall choice, checks, selection
    always_comb begin
        adx  = r_c_dx[15] ? 15'(-r_c_dx) : r_c_dx[14:0];
        ady  = r_c_dy[15] ? 15'(-r_c_dy) : r_c_dy[14:0];
        ax_y = r_c_hy && (!r_c_hx || (r_c_qy < r_c_qx));
        hit  = r_c_hx || r_c_hy;
        d    = ax_y ? r_c_dy : r_c_dx;
        o    = ax_y ? r_c_oy : r_c_ox;
        perp = ax_y ? ady : adx;
        rd   = ax_y ? r_c_rdy : r_c_rdx;
        rt   = 32'(rd) + 32'sd1024;
        rr   = 21'(rt >>> 11);
        coord = (d[15] ? -FH24 : FH24) - 24'(o) - 24'(rr);
        ok   = r_c_use && hit && (perp >= 15'(dswr_pkg::MIN_PERP)) &&
               (coord <= FH24) && (coord >= -FH24);
        bx_ok = (r_c_idx == 2'd0) ? 1'b0 : r_bx_ok;
        by_ok = (r_c_idx == 2'd0) ? 1'b0 : r_by_ok;
        bx_q = r_bx_q; bx_i = r_bx_i; bx_v = r_bx_v;
        by_q = r_by_q; by_i = r_by_i; by_v = r_by_v;
        if (ok && !ax_y && (!bx_ok || perp > bx_q)) begin
            bx_ok = 1'b1; bx_q = perp; bx_i = r_c_idx; bx_v = 16'(coord);
        end
        if (ok && ax_y && (!by_ok || perp > by_q)) begin
            by_ok = 1'b1; by_q = perp; by_i = r_c_idx; by_v = 16'(coord);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_out_v <= 1'b0;
            r_bx_ok <= 1'b0;
            r_by_ok <= 1'b0;
        end else if (adv) begin
            if (issue) begin
                r_idx <= r_idx + 2'd1;
            end
            r_a_v   <= issue;
            r_b_v   <= r_a_v;
            r_c_v   <= r_b_v;
            r_out_v <= r_c_v && (r_c_idx == 2'd3);
            if (r_c_v) begin
                r_bx_ok <= bx_ok;
                r_by_ok <= by_ok;
            end
        end
    end

    // payload, advanced with the pipeline
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_idx <= r_idx;
            r_a_use <= i_cls.use_mask[r_idx];
            r_a_px  <= i_cls.pose_x;
            r_a_py  <= i_cls.pose_y;
            r_a_dx  <= dx;
            r_a_dy  <= dy;
            r_a_r   <= i_cls.reading[r_idx];
            r_a_cmx <= 29'(i_cls.c) * 29'(mnt.x);
            r_a_smy <= 29'(i_cls.s) * 29'(mnt.y);
            r_a_smx <= 29'(i_cls.s) * 29'(mnt.x);
            r_a_cmy <= 29'(i_cls.c) * 29'(mnt.y);

            r_b_idx <= r_a_idx;
            r_b_use <= r_a_use;
            r_b_px  <= r_a_px;
            r_b_py  <= r_a_py;
            r_b_dx  <= r_a_dx;
            r_b_dy  <= r_a_dy;
            r_b_r   <= r_a_r;
            r_b_ox  <= ox;
            r_b_oy  <= oy;
            r_b_hx  <= (r_a_dx != 16'sd0) && (nsx > 19'sd0);
            r_b_hy  <= (r_a_dy != 16'sd0) && (nsy > 19'sd0);
            r_b_nx  <= nsx[16:0];
            r_b_ny  <= nsy[16:0];

            r_c_idx <= r_b_idx;
            r_c_use <= r_b_use;
            r_c_px  <= r_b_px;
            r_c_py  <= r_b_py;
            r_c_dx  <= r_b_dx;
            r_c_dy  <= r_b_dy;
            r_c_ox  <= r_b_ox;
            r_c_oy  <= r_b_oy;
            r_c_hx  <= r_b_hx;
            r_c_hy  <= r_b_hy;
            // nx*|dy| and ny*|dx| compare nearness without dividing
            r_c_qx  <= 32'(r_b_nx) * 32'(r_b_dy[15] ? 15'(-r_b_dy) : r_b_dy[14:0]);
            r_c_qy  <= 32'(r_b_ny) * 32'(r_b_dx[15] ? 15'(-r_b_dx) : r_b_dx[14:0]);
            r_c_rdx <= 31'($signed({17'd0, r_b_r})) * 31'(r_b_dx);
            r_c_rdy <= 31'($signed({17'd0, r_b_r})) * 31'(r_b_dy);

            if (r_c_v) begin
                r_bx_q <= bx_q; r_bx_i <= bx_i; r_bx_v <= bx_v;
                r_by_q <= by_q; r_by_i <= by_i; r_by_v <= by_v;
            end
            if (r_c_v && (r_c_idx == 2'd3)) begin
                r_out.new_x     <= bx_ok ? bx_v : r_c_px;
                r_out.new_y     <= by_ok ? by_v : r_c_py;
                r_out.x_updated <= bx_ok;
                r_out.y_updated <= by_ok;
                r_out.x_sensor  <= bx_ok ? bx_i : 2'd0;
                r_out.y_sensor  <= by_ok ? by_i : 2'd0;
            end
        end
    end
endmodule

@@ hw/rtl/dswr_chk.sv @@
// Port-level checker for the relocalizer, bound to the top level.
// Depends on dswr_pkg and the assertion macro header.
`include "distance_sensor_wall_relocalize_top_assert.svh"

module dswr_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_stall,
    input dswr_pkg::t_out o_data
);
    `DSWR_AST_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data))
    `DSWR_AST_IMP(a_x_idle, o_valid && !o_data.x_updated, o_data.x_sensor == 2'd0)
    `DSWR_AST_IMP(a_y_idle, o_valid && !o_data.y_updated, o_data.y_sensor == 2'd0)
    `DSWR_AST_IMP(a_x_field, o_valid && o_data.x_updated,
        o_data.new_x <= 16'(dswr_pkg::ARENA_HALF) && o_data.new_x >= -16'(dswr_pkg::ARENA_HALF))
endmodule

bind distance_sensor_wall_relocalize_top dswr_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
